FILE: rtl/stw_pkg.sv
// Package for the three-way softmax: widths, fixed-point constants, stage types.
`default_nettype none

package stw_pkg;

  localparam int unsigned SCORE_W   = 24;
  localparam int unsigned PROB_W    = 17;
  localparam int unsigned LANES     = 3;
  localparam int unsigned TERMS     = 14;
  localparam int unsigned QUO_BITS  = 17;

  // log2(e) and ln(2), both unsigned Q32
  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [25:0] UNDER_N   = 26'd40;
  localparam logic [16:0] PROB_ONE  = 17'd65536;

  // floor(2^32 / k) for the series divisors
  localparam logic [32:0] RECIP [1:TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941,
    33'd330382099,  33'd306783378
  };

  typedef struct packed {
    logic [5:0] sh;     // int(m) + 1
    logic       under;  // exp underflows to zero
    logic       zero;   // lane holds the maximum
  } flg_t;

  typedef struct packed {
    logic [29:0] y;     // series argument, Q30
    logic [29:0] p;     // term * y, before division
    logic [30:0] term;  // current series term, Q30
    logic [31:0] sum;   // running series sum, Q30
    flg_t        fl;
  } ser_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [16:0] nlo;
    logic [31:0] dsr;
    logic [16:0] quo;
  } dvs_t;

endpackage

`default_nettype wire

FILE: rtl/stw_if.sv
// Valid/ready channel interfaces for score words and probability words.
`default_nettype none

interface stw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [stw_pkg::SCORE_W-1:0]  score_a;
  logic signed [stw_pkg::SCORE_W-1:0]  score_b;
  logic signed [stw_pkg::SCORE_W-1:0]  score_c;
  modport source (output valid, score_a, score_b, score_c, input ready);
  modport sink   (input valid, score_a, score_b, score_c, output ready);
endinterface

interface stw_out_if;
  logic                         valid;
  logic                         ready;
  logic [stw_pkg::PROB_W-1:0]   prob_a;
  logic [stw_pkg::PROB_W-1:0]   prob_b;
  logic [stw_pkg::PROB_W-1:0]   prob_c;
  modport source (output valid, prob_a, prob_b, prob_c, input ready);
  modport sink   (input valid, prob_a, prob_b, prob_c, output ready);
endinterface

`default_nettype wire

FILE: rtl/softmax_three_way_top.sv
// Throughput: one word per cycle while the skid is empty; 67 pipeline stages (max,
// multiply, split, multiply, series seed, 14 series terms of three stages each, exp shift,
// sum, divider setup, 17-step restoring divider) plus output reg.
// A one-word skid after the pipeline lets input be taken while a result waits.
// Reset (rst_ni low, asynchronous) clears all valid bits, output and skid; data is not reset.
`default_nettype none

module softmax_three_way_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stw_in_if.sink     score_i,
  stw_out_if.source  prob_o
);
  import stw_pkg::*;

  localparam int unsigned NST    = 67;
  localparam int unsigned ST_TOT = 48;
  localparam int unsigned NSER   = 3 * TERMS;

  // global advance: pipeline moves while the skid is empty
  logic            en;
  logic [NST-1:0]  v_q;
  logic            skid_v_q, out_v_q;
  logic [PROB_W-1:0] skid_q [LANES];
  logic [PROB_W-1:0] out_q  [LANES];

  assign en            = !skid_v_q;
  assign score_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], score_i.valid};
    end
  end

  // stage 0: max and magnitudes
  logic signed [SCORE_W-1:0] sc [LANES];
  logic signed [SCORE_W-1:0] mx;
  logic [SCORE_W:0]          dif [LANES];
  logic [SCORE_W-1:0]        mag_q [LANES];

  assign sc[0] = score_i.score_a;
  assign sc[1] = score_i.score_b;
  assign sc[2] = score_i.score_c;

  always_comb begin
    mx = sc[0];
    if (sc[1] > mx) mx = sc[1];
    if (sc[2] > mx) mx = sc[2];
    for (int l = 0; l < LANES; l++) begin
      dif[l] = {mx[SCORE_W-1], mx} - {sc[l][SCORE_W-1], sc[l]};
    end
  end

  // per-lane pipeline through stage 4
  logic [56:0] prod_q [LANES];
  logic        zero1_q [LANES];
  logic [32:0] g_q [LANES];
  flg_t        fl2_q [LANES];
  logic [64:0] yp_q [LANES];
  flg_t        fl3_q [LANES];
  ser_t        ser_q [NSER+1][LANES];
  logic [30:0] e_q [LANES];
  logic [30:0] et_q [LANES];
  logic [31:0] tot_q;
  dvs_t        dv_q [QUO_BITS+1][LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [57:0] msum, mval;
    logic [65:0] yr;

    always_comb begin
      msum = 58'(prod_q[l]) + (58'd1 << (FRAC_BITS - 1));
      mval = msum >> FRAC_BITS;
      yr   = 66'(yp_q[l]) + (66'd1 << 33);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_q[l]   <= dif[l][SCORE_W-1:0];
        // m = mag * log2(e), still scaled by the score fraction
        prod_q[l]  <= 57'(mag_q[l]) * 57'(LOG2E_Q32);
        zero1_q[l] <= (mag_q[l] == '0);
        // split m into integer and fraction, form 1 - frac
        g_q[l]         <= {1'b1, 32'h0} - {1'b0, mval[31:0]};
        fl2_q[l].under <= (mval[57:32] >= UNDER_N);
        fl2_q[l].sh    <= mval[37:32] + 6'd1;
        fl2_q[l].zero  <= zero1_q[l];
        yp_q[l]        <= 65'(g_q[l]) * 65'(LN2_Q32);
        fl3_q[l]       <= fl2_q[l];
        // series seed
        ser_q[0][l].y    <= yr[63:34];
        ser_q[0][l].p    <= '0;
        ser_q[0][l].term <= ONE_Q30;
        ser_q[0][l].sum  <= 32'(ONE_Q30);
        ser_q[0][l].fl   <= fl3_q[l];
      end
    end

    // Taylor terms: multiply by y, reciprocal multiply, then correct the quotient
    for (genvar k = 1; k <= TERMS; k++) begin : g_term
      localparam int unsigned IA = 3 * k - 2;
      logic [60:0] pa;
      logic [62:0] pb;
      logic [34:0] qk, r;
      logic [30:0] q;
      ser_t        st_a_d, st_b_d, st_c_d;

      always_comb begin
        pa = 61'(ser_q[IA-1][l].term) * 61'(ser_q[IA-1][l].y);
        pb = 63'(ser_q[IA][l].p) * 63'(RECIP[k]);
        qk = 35'(ser_q[IA+1][l].term) * 35'(k);
        r  = 35'(ser_q[IA+1][l].p) - qk;
        q  = (r >= 35'(k)) ? ser_q[IA+1][l].term + 31'd1 : ser_q[IA+1][l].term;
        st_a_d      = ser_q[IA-1][l];
        st_a_d.p    = pa[59:30];
        st_b_d      = ser_q[IA][l];
        st_b_d.term = pb[62:32];
        st_c_d      = ser_q[IA+1][l];
        st_c_d.term = q;
        st_c_d.sum  = ser_q[IA+1][l].sum + 32'(q);
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          ser_q[IA][l]   <= st_a_d;
          ser_q[IA+1][l] <= st_b_d;
          ser_q[IA+2][l] <= st_c_d;
        end
      end
    end

    // exp = 2^(1-f) shifted down by int(m) + 1, rounded
    logic [40:0] ext, shv;
    always_comb begin
      ext = 41'(ser_q[NSER][l].sum) + (41'd1 << (ser_q[NSER][l].fl.sh - 6'd1));
      shv = ext >> ser_q[NSER][l].fl.sh;
    end

    // divider setup and restoring steps
    logic [47:0] num;
    assign num = 48'({et_q[l], 16'h0}) + 48'(tot_q >> 1);

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (ser_q[NSER][l].fl.zero) begin
          e_q[l] <= ONE_Q30;
        end else if (ser_q[NSER][l].fl.under) begin
          e_q[l] <= '0;
        end else begin
          e_q[l] <= shv[30:0];
        end
        et_q[l]        <= e_q[l];
        dv_q[0][l].rem <= 32'(num[47:17]);
        dv_q[0][l].nlo <= num[16:0];
        dv_q[0][l].dsr <= tot_q;
        dv_q[0][l].quo <= '0;
      end
    end

    for (genvar d = 1; d <= QUO_BITS; d++) begin : g_div
      logic [32:0] t, ts;
      logic        ge;
      always_comb begin
        t  = {dv_q[d-1][l].rem, dv_q[d-1][l].nlo[16]};
        ts = t - {1'b0, dv_q[d-1][l].dsr};
        ge = (t >= {1'b0, dv_q[d-1][l].dsr});
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_q[d][l].rem <= ge ? ts[31:0] : t[31:0];
          dv_q[d][l].nlo <= {dv_q[d-1][l].nlo[15:0], 1'b0};
          dv_q[d][l].dsr <= dv_q[d-1][l].dsr;
          dv_q[d][l].quo <= {dv_q[d-1][l].quo[15:0], ge};
        end
      end
    end
  end

  // sum of the three exp values
  always_ff @(posedge clk_i) begin
    if (en) begin
      tot_q <= 32'(e_q[0]) + 32'(e_q[1]) + 32'(e_q[2]);
    end
  end

  // saturate the quotients
  logic [PROB_W-1:0] res [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      res[l] = (dv_q[QUO_BITS][l].quo > PROB_ONE) ? PROB_ONE : dv_q[QUO_BITS][l].quo;
    end
  end

  // output register with one-word skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (!out_v_q || prob_o.ready) begin
        out_v_q <= v_q[NST-1];
      end else if (v_q[NST-1]) begin
        skid_v_q <= 1'b1;
      end
    end else if (prob_o.ready) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_v_q || prob_o.ready) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (prob_o.ready) begin
      out_q <= skid_q;
    end
  end

  assign prob_o.valid  = out_v_q;
  assign prob_o.prob_a = out_q[0];
  assign prob_o.prob_b = out_q[1];
  assign prob_o.prob_c = out_q[2];

  // skid only fills behind a waiting output word
  a_skid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full with no output word");

  a_skid_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !prob_o.ready))
    else $error("skid filled while output was free");

  // the maximum lane alone contributes one, so the sum is never below it
  a_tot_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_TOT] |-> (tot_q >= 32'(ONE_Q30))) else $error("exp sum below one");

  a_prob_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q[0] <= PROB_ONE && out_q[1] <= PROB_ONE && out_q[2] <= PROB_ONE))
    else $error("probability above one");

endmodule

`default_nettype wire
